// ===== rtl/rcu_pkg.sv =====
package rcu_pkg;

  localparam int CHANNELS_DEF          = 32;
  localparam int PAYLOAD_BYTES_DEF     = 33;
  localparam int FALLBACK_CHANNELS_DEF = 18;

  localparam int TYPE_BITS  = 160;
  localparam int POS_W      = 9;   // 32 channels of up to 15 bits
  localparam int IDX_W      = 7;   // byte index plus two look-ahead bytes
  localparam int CNT_W      = 6;   // channel counter, holds 32
  localparam int PULSE_W    = 12;
  localparam int CH_W       = 5;

  localparam logic [11:0] PULSE_CENTER = 12'd1500;
  localparam logic [11:0] PULSE_MIN    = 12'd750;
  localparam logic [11:0] PULSE_MAX    = 12'd2250;
  localparam logic [14:0] VALUE_SAT    = 15'd24576;
  localparam logic [16:0] VALUE_OFFSET = 17'd49152;
  localparam logic [12:0] MAP_GAIN     = 13'd8000;
  localparam logic [13:0] SCALED_MIN   = 14'd3000;
  localparam logic [13:0] SCALED_MAX   = 14'd9000;
  localparam logic [7:0]  DIV3_RECIP   = 8'd171;

  localparam logic [1:0] REG_TYPES_LOW  = 2'd0;
  localparam logic [1:0] REG_TYPES_MID  = 2'd1;
  localparam logic [1:0] REG_TYPES_HIGH = 2'd2;
  localparam logic [1:0] REG_TYPES_VLD  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_FIELD, S_MUL, S_MAP, S_PULSE, S_OUT
  } state_t;

  // Scale factor per channel type, 16 fractional bits after the product shift
  function automatic logic [31:0] scale_factor(input logic [4:0] t);
    logic [31:0] f;
    begin
      unique case (t)
        5'd2:  f = 32'h40000000;
        5'd6:  f = 32'h028F5C29;
        5'd7:  f = 32'h0147AE15;
        5'd8:  f = 32'h0083126F;
        5'd9:  f = 32'h00418938;
        5'd10: f = 32'h0020C49C;
        5'd11: f = 32'h0010624E;
        5'd12: f = 32'h00083127;
        5'd13: f = 32'h00041894;
        5'd19: f = 32'h20000000;
        5'd20: f = 32'h10000000;
        5'd21: f = 32'h06666667;
        5'd22: f = 32'h03333334;
        5'd24: f = 32'h0147AE15;
        5'd25: f = 32'h00A3D70B;
        5'd26: f = 32'h00418938;
        5'd27: f = 32'h0020C49C;
        5'd28: f = 32'h0010624E;
        5'd29: f = 32'h00083127;
        default: f = 32'h0;
      endcase
      return f;
    end
  endfunction

endpackage

// ===== rtl/rcu_payload_mem.sv =====
module rcu_payload_mem
  import rcu_pkg::*;
#(
  parameter int DEPTH = PAYLOAD_BYTES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write one byte, read one byte with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rcu_held_mem.sv =====
module rcu_held_mem
  import rcu_pkg::*;
#(
  parameter int DEPTH = CHANNELS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [PULSE_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [PULSE_W-1:0] rdata
);

  logic [PULSE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  logic [PULSE_W-1:0] q;
  logic               qv;

  // Store entries and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

  // Track written entries; unwritten ones read as the center pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      qv  <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      qv <= vld[raddr] | (we && waddr == raddr);
    end
  end

  assign rdata = qv ? q : PULSE_CENTER;

endmodule

// ===== rtl/rc_channel_unpacker_variable_width_core.sv =====
// Decode: a frame-ending beat starts decode when types are valid or the frame
// holds at least four untyped channels; each channel steps through four payload
// memory read states, field extract, multiply, map, pulse and output beat, and the
// output beat waits for the master side. No input is taken while a decode runs,
// and the per-channel sequencer handles one channel at a time. Synchronous active-high
// reset clears byte count, config registers, held-pulse valid bits (all channels read 1500) and the sequencer state.
module rc_channel_unpacker_variable_width_core
  import rcu_pkg::*;
#(
  parameter int CHANNELS          = CHANNELS_DEF,
  parameter int PAYLOAD_BYTES     = PAYLOAD_BYTES_DEF,
  parameter int FALLBACK_CHANNELS = FALLBACK_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // payload_byte
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // channel_index[4:0], pulse_us[16:5], zero fill
  output logic        m_tlast,   // last_channel
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW       = $clog2(PAYLOAD_BYTES);
  localparam int BCW      = $clog2(PAYLOAD_BYTES + 1);
  localparam int HW       = $clog2(CHANNELS);
  localparam int FB_BYTES = (FALLBACK_CHANNELS * 12) / 8;

  state_t state, state_next;

  logic [TYPE_BITS-1:0] types;
  logic                 types_valid;
  logic [BCW-1:0]       byte_count;
  logic [CNT_W-1:0]     ch;
  logic [CNT_W-1:0]     total;
  logic                 typed;
  logic [POS_W-1:0]     pos;
  logic [7:0]           d0, d1;
  logic [7:0]           mem_q;
  logic [PULSE_W-1:0]   held_q, held_val;
  logic                 hold;
  logic                 neg;
  logic [13:0]          mag;
  logic [PULSE_W-1:0]   unt_pulse;
  logic [45:0]          prod;
  logic [29:0]          mapped;
  logic [PULSE_W-1:0]   out_pulse;
  logic [CH_W-1:0]      out_ch;
  logic                 out_last;

  logic                 s_acc, m_acc;
  logic                 mem_we, held_we;
  logic [IDX_W-1:0]     rd_idx;
  logic [PULSE_W-1:0]   pulse_calc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      types       <= '0;
      types_valid <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TYPES_LOW:  types[63:0]    <= cfg_data;
        REG_TYPES_MID:  types[127:64]  <= cfg_data;
        REG_TYPES_HIGH: types[159:128] <= cfg_data[31:0];
        REG_TYPES_VLD:  types_valid    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Frame length and channel count at frame end
  logic [BCW-1:0]   bc_after;
  logic [CNT_W-1:0] unt_count;
  logic [16:0]      div3;
  logic [CNT_W-1:0] fb_lim;
  always_comb begin
    bc_after = (byte_count < BCW'(PAYLOAD_BYTES)) ? byte_count + 1'b1 : byte_count;
    div3     = 17'({bc_after, 1'b0}) * 17'(DIV3_RECIP);
    fb_lim   = (bc_after >= BCW'(FB_BYTES)) ? CNT_W'(FALLBACK_CHANNELS)
                                             : CNT_W'(div3 >> 9);
    unt_count = (fb_lim > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : fb_lim;
  end

  // Current channel type and width
  logic [4:0] ch_type;
  logic [3:0] n;
  assign ch_type = types[5 * ch[CH_W-1:0] +: 5];
  assign n       = typed ? ch_type[3:0] : 4'd12;

  // Field extract from the three-byte window, bytes past the frame read zero
  logic [IDX_W-1:0] b0;
  logic [23:0]      win;
  logic [23:0]      shifted;
  logic [14:0]      field;
  logic [14:0]      top;
  logic [14:0]      negf;
  logic signed [11:0] raw;
  logic signed [11:0] half;
  logic signed [12:0] unt_sum;
  assign b0 = IDX_W'(pos[POS_W-1:3]);
  always_comb begin
    win[7:0]   = (b0 < IDX_W'(byte_count))        ? d0 : 8'h0;
    win[15:8]  = (b0 + 1'b1 < IDX_W'(byte_count)) ? d1 : 8'h0;
    win[23:16] = (b0 + 2'd2 < IDX_W'(byte_count)) ? mem_q : 8'h0;
    shifted    = win >> pos[2:0];
    field      = shifted[14:0] & ((15'd1 << n) - 15'd1);
    top        = (n >= 4'd2) ? (15'd1 << (n - 4'd1)) : 15'd0;
    negf       = (15'd0 - field) & (top - 15'd1);
    raw        = signed'(shifted[11:0]);
    half       = (raw + $signed({11'd0, raw[11]})) >>> 1;
    unt_sum    = 13'(PULSE_CENTER) + 13'(half);
  end

  // Scaled value, saturated and signed
  logic [30:0]        sc_full;
  logic [14:0]        sc;
  logic signed [16:0] value;
  logic [16:0]        offs;
  logic [13:0]        s_round;
  logic [13:0]        s_clamp;
  always_comb begin
    sc_full    = 31'((prod + 46'd32768) >> 16);
    sc         = (sc_full > 31'(VALUE_SAT)) ? VALUE_SAT : sc_full[14:0];
    value      = neg ? -17'(sc) : 17'(sc);
    offs       = 17'(value) + VALUE_OFFSET;
    s_round    = 14'((mapped + 30'd32768) >> 16);
    s_clamp    = (s_round < SCALED_MIN) ? SCALED_MIN :
                 (s_round > SCALED_MAX) ? SCALED_MAX : s_round;
    pulse_calc = hold  ? held_val :
                 typed ? s_clamp[13:2] : unt_pulse;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_acc && s_tlast && (types_valid || unt_count >= CNT_W'(4)))
                 state_next = S_RD0;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_RD3;
      S_RD3:   state_next = S_FIELD;
      S_FIELD: state_next = S_MUL;
      S_MUL:   state_next = S_MAP;
      S_MAP:   state_next = S_PULSE;
      S_PULSE: state_next = S_OUT;
      S_OUT:   if (m_acc) state_next = out_last ? S_IDLE : S_RD0;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready = (state == S_IDLE);
    m_tvalid = (state == S_OUT);
    mem_we   = s_acc && (byte_count < BCW'(PAYLOAD_BYTES));
    held_we  = (state == S_PULSE) && !hold;
    unique case (state)
      S_RD1:   rd_idx = b0 + 1'b1;
      S_RD2:   rd_idx = b0 + 2'd2;
      S_RD3:   rd_idx = b0 + 2'd2;
      default: rd_idx = b0;
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= '0;
      ch         <= '0;
      pos        <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && s_acc) begin
        byte_count <= s_tlast ? ((types_valid || unt_count >= CNT_W'(4)) ? bc_after : '0)
                              : bc_after;
        ch  <= '0;
        pos <= '0;
      end
      if (state == S_OUT && m_acc) begin
        ch  <= ch + 1'b1;
        pos <= pos + POS_W'(n);
        if (out_last) byte_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_acc && s_tlast) begin
      typed <= types_valid;
      total <= types_valid ? CNT_W'(CHANNELS) : unt_count;
    end
    if (state == S_RD1) begin
      d0       <= mem_q;
      held_val <= held_q;
    end
    if (state == S_RD2) d1 <= mem_q;
    if (state == S_FIELD) begin
      hold <= typed && n >= 4'd2 &&
              (field == top || (field == top + 15'd1 && n >= 4'd6));
      neg  <= typed && n >= 4'd2 && (field & top) != 15'd0;
      mag  <= (!typed || n < 4'd2) ? 14'd0 :
              ((field & top) != 15'd0) ? negf[13:0] : field[13:0];
      unt_pulse <= (unt_sum < 13'(PULSE_MIN)) ? PULSE_MIN :
                   (unt_sum > 13'(PULSE_MAX)) ? PULSE_MAX : unt_sum[11:0];
    end
    if (state == S_MUL) prod <= 46'(mag) * 46'(scale_factor(ch_type));
    if (state == S_MAP) mapped <= 30'(offs) * 30'(MAP_GAIN);
    if (state == S_PULSE) begin
      out_pulse <= pulse_calc;
      out_ch    <= ch[CH_W-1:0];
      out_last  <= (ch + 1'b1 == total);
    end
  end

  rcu_payload_mem #(.DEPTH(PAYLOAD_BYTES)) u_payload (
    .clk   (clk),
    .we    (mem_we),
    .waddr (byte_count[AW-1:0]),
    .wdata (s_tdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (mem_q)
  );

  rcu_held_mem #(.DEPTH(CHANNELS)) u_held (
    .clk   (clk),
    .rst   (rst),
    .we    (held_we),
    .waddr (ch[HW-1:0]),
    .wdata (pulse_calc),
    .raddr (ch[HW-1:0]),
    .rdata (held_q)
  );

  assign m_tdata = {7'd0, out_pulse, out_ch};
  assign m_tlast = out_last;

  // Never be ready for input while an output beat is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken during decode");

  // Channel counter stays below the frame's channel count while decoding
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (ch < total)) else $error("channel count overrun");

  // Pulse output stays within the clamp range
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_pulse >= PULSE_MIN && out_pulse <= PULSE_MAX))
    else $error("pulse out of range");

  // Byte count is cleared after the final beat of a frame
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (m_acc && m_tlast) |=> (byte_count == '0)) else $error("byte count not cleared");

endmodule

// ===== tb/sv/rc_channel_unpacker_variable_width_core_test.sv =====
`timescale 1ns / 1ps

module rc_channel_unpacker_variable_width_core_test;
  import rcu_pkg::*;

  localparam int NCH       = 32;
  localparam int NBYTES    = 33;
  localparam int NFALLBACK = 18;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [4:0]  chan;
    logic [11:0] pulse;
    logic        last;
  } pulse_beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  // predictor state
  logic [159:0] type_vec;
  logic         typed_mode;
  logic [7:0]   frame_bytes [NBYTES];
  int           frame_len;
  logic [11:0]  held_us [NCH];

  pulse_beat_t  pending_pulses [$];
  int           fail_count;
  int           idle_cycles;

  rc_channel_unpacker_variable_width_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] type_gain(input logic [4:0] t);
    case (t)
      5'd2:  return 32'h40000000;
      5'd6:  return 32'h028F5C29;
      5'd7:  return 32'h0147AE15;
      5'd8:  return 32'h0083126F;
      5'd9:  return 32'h00418938;
      5'd10: return 32'h0020C49C;
      5'd11: return 32'h0010624E;
      5'd12: return 32'h00083127;
      5'd13: return 32'h00041894;
      5'd19: return 32'h20000000;
      5'd20: return 32'h10000000;
      5'd21: return 32'h06666667;
      5'd22: return 32'h03333334;
      5'd24: return 32'h0147AE15;
      5'd25: return 32'h00A3D70B;
      5'd26: return 32'h00418938;
      5'd27: return 32'h0020C49C;
      5'd28: return 32'h0010624E;
      5'd29: return 32'h00083127;
      default: return 32'h0;
    endcase
  endfunction

  // read n payload bits from pos; bytes past the frame read as zero
  function automatic logic [31:0] frame_field(input int pos, input int n);
    logic [31:0] v;
    int b;
    v = '0;
    for (int k = 0; k < n; k++) begin
      b = (pos + k) >> 3;
      if (b < frame_len && b < NBYTES)
        v[k] = frame_bytes[b][(pos + k) & 7];
    end
    return v;
  endfunction

  function automatic void push_pulse(input int c, input logic [11:0] p, input bit last);
    pulse_beat_t e;
    e.chan  = c[4:0];
    e.pulse = p;
    e.last  = last;
    pending_pulses.push_back(e);
  endfunction

  // decode one complete frame into expected channel pulses
  function automatic void decode_frame();
    int pos, n, cnt;
    logic [4:0] t;
    logic [31:0] field, top;
    longint mag, sc, value, s, raw, p;
    bit neg;
    if (typed_mode) begin
      pos = 0;
      for (int c = 0; c < NCH; c++) begin
        t = type_vec[c*5 +: 5];
        n = t[3:0];
        value = 0;
        if (n >= 2) begin
          field = frame_field(pos, n);
          top = 32'd1 << (n - 1);
          if (field == top || (field == top + 1 && n >= 6)) begin
            pos += n;
            push_pulse(c, held_us[c], c == NCH - 1);
            continue;
          end
          neg = (field & top) != 0;
          mag = neg ? ((0 - field) & (top - 1)) : field;
          sc = (mag * longint'(type_gain(t)) + 32768) >>> 16;
          if (sc > 24576) sc = 24576;
          value = neg ? -sc : sc;
        end
        pos += n;
        s = ((value + 49152) * 8000 + 32768) >>> 16;
        if (s < 3000) s = 3000;
        if (s > 9000) s = 9000;
        held_us[c] = 12'(s / 4);
        push_pulse(c, held_us[c], c == NCH - 1);
      end
    end else begin
      cnt = (frame_len >= NFALLBACK * 12 / 8) ? NFALLBACK : frame_len * 8 / 12;
      if (cnt > NCH) cnt = NCH;
      if (cnt >= 4) begin
        for (int i = 0; i < cnt; i++) begin
          field = frame_field(i * 12, 12);
          raw = field[11] ? longint'(field) - 4096 : longint'(field);
          p = 1500 + raw / 2;
          if (p < 750) p = 750;
          if (p > 2250) p = 2250;
          held_us[i] = 12'(p);
          push_pulse(i, 12'(p), i == cnt - 1);
        end
      end
    end
    frame_len = 0;
  endfunction

  // send one payload beat after a random gap, then update the predictor
  task automatic send_byte(input logic [7:0] b, input bit fin);
    int gap;
    gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (frame_len < NBYTES) begin
      frame_bytes[frame_len] = b;
      frame_len++;
    end
    if (fin) decode_frame();
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input int style);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (style)
        1: b = 8'h00;
        2: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // let the block drain before touching registers
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TYPES_LOW:  type_vec[63:0]    = val;
      REG_TYPES_MID:  type_vec[127:64]  = val;
      REG_TYPES_HIGH: type_vec[159:128] = val[31:0];
      REG_TYPES_VLD:  typed_mode        = val[0];
      default: ;
    endcase
  endtask

  task automatic set_types(input logic [159:0] tv, input bit vld);
    wait_drained();
    write_reg(REG_TYPES_LOW, tv[63:0]);
    write_reg(REG_TYPES_MID, tv[127:64]);
    write_reg(REG_TYPES_HIGH, {32'($urandom), tv[159:128]});
    write_reg(REG_TYPES_VLD, {63'($urandom), vld});
  endtask

  function automatic logic [159:0] uniform_types(input logic [4:0] t);
    logic [159:0] v;
    for (int c = 0; c < NCH; c++) v[c*5 +: 5] = t;
    return v;
  endfunction

  function automatic logic [159:0] random_types();
    logic [159:0] v;
    for (int c = 0; c < NCH; c++) v[c*5 +: 5] = 5'($urandom);
    return v;
  endfunction

  // untyped decode: short frames, boundary lengths, overlong frames
  task automatic test_fallback_directed();
    send_frame(1, 0);
    send_frame(5, 2);
    send_frame(6, 2);
    send_frame(27, 1);
    send_frame(40, 2);
  endtask

  // typed decode: extremes, keep and stop codes, zero-factor types
  task automatic test_typed_directed();
    set_types(uniform_types(5'd11), 1'b1);
    send_frame(NBYTES, 2);
    send_frame(NBYTES, 1);
    set_types(uniform_types(5'd2), 1'b1);
    send_frame(8, 0);
    set_types(uniform_types(5'd22), 1'b1);
    // keep code 0x20 then stop code 0x21 in 6-bit fields
    send_byte(8'h60, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h02, 1'b1);
    set_types(uniform_types(5'd31), 1'b1);
    send_frame(4, 0);
  endtask

  // mostly well-formed frames with random content and random type maps
  task automatic test_random_frames();
    int sent, len;
    sent = 0;
    while (sent < 260) begin
      if (($urandom % 5) == 0) begin
        if (($urandom % 3) == 0) set_types(random_types(), 1'b0);
        else set_types(random_types(), 1'b1);
      end
      case ($urandom % 6)
        0: len = $urandom_range(1, 8);
        1: len = $urandom_range(34, 40);
        default: len = $urandom_range(20, 33);
      endcase
      send_frame(len, 0);
      sent += len;
    end
  endtask

  // compare each output beat with the oldest expected pulse
  always @(posedge clk) begin
    pulse_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pulses.size() == 0) begin
        $error("unexpected beat chan=%0d pulse=%0d", m_tdata[4:0], m_tdata[16:5]);
        fail_count++;
      end else begin
        e = pending_pulses.pop_front();
        if (m_tdata[4:0] !== e.chan) begin
          $error("channel_index expected %0d got %0d", e.chan, m_tdata[4:0]);
          fail_count++;
        end
        if (m_tdata[16:5] !== e.pulse) begin
          $error("pulse_us expected %0d got %0d", e.pulse, m_tdata[16:5]);
          fail_count++;
        end
        if (m_tlast !== e.last) begin
          $error("last_channel expected %0d got %0d", e.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // random receiver stalls, with calm stretches
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = (($urandom % 3) == 0) ? 0 : $urandom_range(0, 14);
      m_tready <= 1'b0;
      repeat (stall) @(negedge clk);
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // stop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    fail_count = 0;
    idle_cycles = 0;
    type_vec = '0;
    typed_mode = 1'b0;
    frame_len = 0;
    for (int c = 0; c < NCH; c++) held_us[c] = 12'd1500;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_fallback_directed();
    test_typed_directed();
    set_types(uniform_types(5'd0), 1'b0);
    test_random_frames();
    wait_drained();
    if (fail_count == 0 && pending_pulses.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
